// ===== rtl/efp_pkg.sv =====
// package for the encoder frame parser: frame constants and shared types
`timescale 1ns / 1ps

package efp_pkg;

	// total frame length including the two header bytes
	localparam int unsigned FRAME_BYTES = 17;
	localparam int unsigned POS_W = 5;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h01;
	localparam logic [7:0] TRL_FIRST  = 8'h0D;
	localparam logic [7:0] TRL_SECOND = 8'h0A;

	// positions within a frame
	localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HDR2    = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEFT0   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEFT3   = POS_W'(5);
	localparam logic [POS_W-1:0] POS_RIGHT0  = POS_W'(6);
	localparam logic [POS_W-1:0] POS_RIGHT3  = POS_W'(9);
	localparam logic [POS_W-1:0] POS_TRL1    = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_TRL2    = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_END     = POS_W'(FRAME_BYTES);

	typedef struct packed {
		logic        emit;
		logic [31:0] left_count;
		logic [31:0] right_count;
	} efp_result_t;

endpackage

// ===== rtl/efp_in_if.sv =====
// request channel carrying received bytes
`timescale 1ns / 1ps

interface efp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/efp_out_if.sv =====
// request channel carrying decoded encoder counts
`timescale 1ns / 1ps

interface efp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] left_count;
	logic [31:0] right_count;

	modport source (output valid, output left_count, output right_count, input ready);
	modport sink (input valid, input left_count, input right_count, output ready);
endinterface

// ===== rtl/efp_parser.sv =====
// frame state tracker: header hunt, count gathering and trailer check
`timescale 1ns / 1ps

module efp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           rx_byte,
	output efp_pkg::efp_result_t result
);

	logic [efp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [31:0]               left_q, left_d;
	logic [31:0]               right_q, right_d;
	logic                      trl_ok_q, trl_ok_d;
	logic [1:0]                lane_l, lane_r;
	logic                      emit;

	assign lane_l = 2'(pos_q - efp_pkg::POS_LEFT0);
	assign lane_r = 2'(pos_q - efp_pkg::POS_RIGHT0);

	always_comb begin
		pos_d    = pos_q;
		left_d   = left_q;
		right_d  = right_q;
		trl_ok_d = trl_ok_q;
		emit     = 1'b0;
		if (pos_q == efp_pkg::POS_HUNT || pos_q >= efp_pkg::POS_END) begin
			pos_d = (rx_byte == efp_pkg::HDR_FIRST) ? efp_pkg::POS_HDR2 : efp_pkg::POS_HUNT;
		end else if (pos_q == efp_pkg::POS_HDR2) begin
			if (rx_byte == efp_pkg::HDR_SECOND) begin
				pos_d    = efp_pkg::POS_LEFT0;
				left_d   = '0;
				right_d  = '0;
				trl_ok_d = 1'b0;
			end else if (rx_byte == efp_pkg::HDR_FIRST) begin
				// repeated 0xaa starts the header afresh
				pos_d = efp_pkg::POS_HDR2;
			end else begin
				pos_d = efp_pkg::POS_HUNT;
			end
		end else if (pos_q == efp_pkg::POS_TRL2) begin
			pos_d = efp_pkg::POS_HUNT;
			emit  = trl_ok_q && (rx_byte == efp_pkg::TRL_SECOND);
		end else if (pos_q == efp_pkg::POS_TRL1) begin
			trl_ok_d = (rx_byte == efp_pkg::TRL_FIRST);
			pos_d    = pos_q + efp_pkg::POS_W'(1);
		end else begin
			if (pos_q <= efp_pkg::POS_LEFT3) begin
				left_d[{lane_l, 3'b000} +: 8] = rx_byte;
			end else if (pos_q <= efp_pkg::POS_RIGHT3) begin
				right_d[{lane_r, 3'b000} +: 8] = rx_byte;
			end
			pos_d = pos_q + efp_pkg::POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= efp_pkg::POS_HUNT;
			left_q   <= '0;
			right_q  <= '0;
			trl_ok_q <= 1'b0;
		end else if (take) begin
			pos_q    <= pos_d;
			left_q   <= left_d;
			right_q  <= right_d;
			trl_ok_q <= trl_ok_d;
		end
	end

	assign result.emit        = take && emit;
	assign result.left_count  = left_q;
	assign result.right_count = right_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < efp_pkg::POS_END)
		else $error("frame position out of range");

	a_emit_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		result.emit |-> (pos_q == efp_pkg::POS_TRL2 && trl_ok_q))
		else $error("result outside frame end");

	a_header_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pos_q == efp_pkg::POS_HDR2 && rx_byte == efp_pkg::HDR_SECOND)
		|=> (pos_q == efp_pkg::POS_LEFT0 && !trl_ok_q))
		else $error("header did not open a frame");

	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && pos_q == efp_pkg::POS_TRL2) |=> pos_q == efp_pkg::POS_HUNT)
		else $error("no return to hunting after frame");

endmodule

// ===== rtl/efp_out_stage.sv =====
// result register between the parser and the count channel
`timescale 1ns / 1ps

module efp_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  efp_pkg::efp_result_t result,
	output logic                 full,
	efp_out_if.source            counts
);

	logic        valid_q;
	logic [31:0] left_q;
	logic [31:0] right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result.emit) begin
			valid_q <= 1'b1;
		end else if (counts.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.emit) begin
			left_q  <= result.left_count;
			right_q <= result.right_count;
		end
	end

	assign full               = valid_q;
	assign counts.valid       = valid_q;
	assign counts.left_count  = left_q;
	assign counts.right_count = right_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		result.emit |=> valid_q)
		else $error("loaded result not shown");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !counts.ready) |-> !result.emit)
		else $error("waiting result overwritten");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && counts.ready && !result.emit) |=> !valid_q)
		else $error("taken result not cleared");

endmodule

// ===== rtl/encoder_frame_parser.sv =====
// top level of the wheel encoder frame parser
`timescale 1ns / 1ps

// takes one received byte per cycle on rx and hunts for frames that open with
// 0xaa 0x01 and close with 0x0d 0x0a; a frame is efp_pkg::FRAME_BYTES long,
// bytes 2-5 and 6-9 give the left and right counts, little endian. a good frame
// yields one request on counts, shown from the cycle after its closing byte is
// taken. rx stays ready every cycle except while a finished result waits on
// counts with ready low; the result register is the only point of stall.
// bad frames vanish without a request and hunting resumes at the next byte.
module encoder_frame_parser (
	input  logic      clk,
	input  logic      arst_n,
	efp_in_if.sink    rx,
	efp_out_if.source counts
);

	efp_pkg::efp_result_t result;
	logic                 full;
	logic                 take;

	// a waiting result blocks new bytes only when it is not being taken
	assign rx.ready = !full || counts.ready;
	assign take     = rx.valid && rx.ready;

	efp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx.rx_byte),
		.result  (result)
	);

	efp_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.result (result),
		.full   (full),
		.counts (counts)
	);

endmodule
